>>> rtl/sqc_pkg.sv
// ----------------------------------------------------------------------------
// sqc_pkg
// Shared codes, widths, control/status bundles and code-width helpers for the
// scalar quantizer codec.
// ----------------------------------------------------------------------------
package sqc_pkg;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_ENC  = 2'd1;
	localparam logic [1:0] OP_DEC  = 2'd2;

	localparam logic [1:0] REG_QTYPE  = 2'd0;
	localparam logic [1:0] REG_QMODE  = 2'd1;
	localparam logic [1:0] REG_DIMS   = 2'd2;
	localparam logic [1:0] REG_THRESH = 2'd3;

	localparam logic [2:0] QT_BIN   = 3'd0;
	localparam logic [2:0] QT_TER   = 3'd1;
	localparam logic [2:0] QT_TWO   = 3'd2;
	localparam logic [2:0] QT_FOUR  = 3'd3;
	localparam logic [2:0] QT_EIGHT = 3'd4;

	localparam int POS_W = 11;
	localparam int CFG_W = 23;
	localparam int NUM_W = 42;
	localparam int DEN_W = 34;
	localparam int QUO_W = 34;

	localparam logic [2:0]       QTYPE_RST  = QT_EIGHT;
	localparam logic             QMODE_RST  = 1'b1;
	localparam logic [POS_W-1:0] DIMS_RST   = 11'd128;
	localparam logic [CFG_W-1:0] THRESH_RST = 23'd32768;

	typedef struct packed {
		logic load;
		logic rd;
		logic rng;
		logic p1;
		logic p2;
		logic p3;
		logic div_start;
		logic fin;
		logic step;
	} sqc_cmd_t;

	typedef struct packed {
		logic in_elem;
		logic div_need;
		logic div_busy;
		logic need_out;
		logic out_free;
		logic elem_last;
	} sqc_sts_t;

	function automatic logic [3:0] bits_of(input logic [2:0] qt);
		case (qt)
			QT_BIN:         return 4'd1;
			QT_TER, QT_TWO: return 4'd2;
			QT_FOUR:        return 4'd4;
			default:        return 4'd8;
		endcase
	endfunction

	function automatic logic [3:0] per_of(input logic [2:0] qt);
		case (qt)
			QT_BIN:         return 4'd8;
			QT_TER, QT_TWO: return 4'd4;
			QT_FOUR:        return 4'd2;
			default:        return 4'd1;
		endcase
	endfunction

	function automatic logic [7:0] lm1_of(input logic [2:0] qt);
		case (qt)
			QT_BIN:  return 8'd1;
			QT_TER:  return 8'd2;
			QT_TWO:  return 8'd3;
			QT_FOUR: return 8'd15;
			default: return 8'd255;
		endcase
	endfunction

	function automatic logic [7:0] mask_of(input logic [2:0] qt);
		case (qt)
			QT_BIN:         return 8'd1;
			QT_TER, QT_TWO: return 8'd3;
			QT_FOUR:        return 8'd15;
			default:        return 8'd255;
		endcase
	endfunction

endpackage

>>> rtl/sqc_div.sv
// ----------------------------------------------------------------------------
// sqc_div
// Radix-2 restoring divider, one quotient bit per cycle. The numerator's top
// bits must be below the divisor so that the quotient fits QUO_W bits.
// ----------------------------------------------------------------------------
module sqc_div import sqc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [QUO_W-1:0] quo
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   rem_q;
	logic [QUO_W-1:0] sh_q;
	logic [DEN_W:0]   shifted;
	logic             ge;

	assign shifted = {rem_q[DEN_W-1:0], sh_q[QUO_W-1]};
	assign ge      = shifted >= {1'b0, den};
	assign busy    = cnt_q != '0;
	assign quo     = sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(QUO_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (DEN_W+1)'(num[NUM_W-1:QUO_W]);
			sh_q  <= num[QUO_W-1:0];
		end else if (busy) begin
			rem_q <= ge ? (shifted - {1'b0, den}) : shifted;
			sh_q  <= {sh_q[QUO_W-2:0], ge};
		end
	end

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy)
		else $error("divider did not go busy after start");

endmodule

>>> rtl/sqc_dp.sv
// ----------------------------------------------------------------------------
// sqc_dp
// Datapath: configuration, statistics memory, range and code arithmetic,
// shared divider, code packing and the output register.
// ----------------------------------------------------------------------------
module sqc_dp import sqc_pkg::*; #(
	parameter int DIM_MAX   = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         cmd,
	input  logic [9:0]         dim_index,
	input  logic signed [31:0] comp_value,
	input  logic [7:0]         code_in,
	input  logic signed [31:0] stat_min,
	input  logic signed [31:0] stat_max,
	input  logic signed [31:0] stat_mean,
	input  logic [30:0]        stat_std,
	input  logic               vec_last,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [CFG_W-1:0]   wr_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic [7:0]         packed_code,
	output logic signed [31:0] recon_value,
	output logic               run_last,
	output logic               length_error,
	input  sqc_cmd_t           ctl,
	output sqc_sts_t           sts
);

	localparam int AW = $clog2(DIM_MAX);
	localparam int XW = 17;

	typedef struct packed {
		logic signed [31:0] mn;
		logic signed [31:0] mx;
		logic signed [31:0] mean;
		logic [30:0]        sd;
	} stat_row_t;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
		else if (v < -36'sd2147483648) return 32'sh80000000;
		else return v[31:0];
	endfunction

	stat_row_t mem [DIM_MAX];

	logic [2:0]         qtype_q;
	logic               qmode_q;
	logic [POS_W-1:0]   dims_q;
	logic [CFG_W-1:0]   thr_q;

	logic [1:0]         cmd_q;
	logic signed [31:0] comp_q;
	logic [7:0]         code_q;
	logic               last_q;
	logic [POS_W-1:0]   pos_q;
	logic [7:0]         acc_q;
	logic [2:0]         k_q;
	logic [3:0]         cnt_q;
	logic               ok_q;

	stat_row_t          rd_s1;
	logic               oor_s1;
	logic signed [31:0] lo_s2, hi_s2;
	logic [30:0]        std_s2;
	logic [53:0]        thp_s2;
	logic signed [32:0] n_s3, d_s3;
	logic               le_s3, npos_s3, nlt_s3, gt_s3, lt_s3;
	logic signed [41:0] prod_s4;
	logic [NUM_W-1:0]   num_s5;
	logic [DEN_W-1:0]   den_s5;
	logic               neg_s5;
	logic [7:0]         fcode_q;
	logic signed [31:0] fval_q;

	logic               out_valid_q, kind_q, run_last_q, lerr_q;
	logic [7:0]         packed_q;
	logic signed [31:0] recon_q;

	logic [3:0]         bits, per;
	logic [7:0]         lm1, mask;
	logic [XW-1:0]      wr_x, rd_x;
	logic [11:0]        p12, dims12, count;
	logic               dok;
	logic [3:0]         n_dec;
	logic [2:0]         slot;
	logic [7:0]         used_bits;
	logic [2:0]         sh;
	logic [7:0]         ecode, placed, acc_new;
	logic               emit_enc, elem_last, fin_dec;
	logic signed [31:0] r_mn, r_mx, r_mean;
	logic [30:0]        r_sd;
	logic [32:0]        half;
	logic signed [35:0] mean36, half36;
	logic signed [54:0] val55, t55;
	logic signed [32:0] mul_a;
	logic signed [8:0]  mul_b;
	logic signed [41:0] prod;
	logic signed [42:0] p2x, a_dec, an_dec;
	logic signed [35:0] sq, vsum;
	logic               div_busy;
	logic [QUO_W-1:0]   quo;
	logic signed [31:0] one_fx, std_fx;

	assign bits = bits_of(qtype_q);
	assign per  = per_of(qtype_q);
	assign lm1  = lm1_of(qtype_q);
	assign mask = mask_of(qtype_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qtype_q <= QTYPE_RST;
			qmode_q <= QMODE_RST;
			dims_q  <= DIMS_RST;
			thr_q   <= THRESH_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_QTYPE:  qtype_q <= wr_data[2:0];
				REG_QMODE:  qmode_q <= wr_data[0];
				REG_DIMS:   dims_q  <= wr_data[POS_W-1:0];
				REG_THRESH: thr_q   <= wr_data;
			endcase
		end
	end

	assign wr_x = XW'(dim_index);
	assign rd_x = XW'(POS_W'(pos_q + POS_W'(k_q)));

	always_ff @(posedge clk) begin
		if (ctl.load && cmd == OP_LOAD && wr_x < XW'(DIM_MAX)) begin
			mem[wr_x[AW-1:0]] <= '{stat_min, stat_max, stat_mean, stat_std};
		end
		if (ctl.rd) begin
			rd_s1  <= mem[rd_x[AW-1:0]];
			oor_s1 <= !(rd_x < XW'(DIM_MAX));
		end
	end

	assign p12    = {1'b0, pos_q};
	assign dims12 = {1'b0, dims_q};
	assign count  = p12 + 12'd1;
	assign dok    = (dims_q != '0) && (p12 <= dims12 - 12'd1)
		&& (dims12 - 12'd1 < p12 + 12'(per));
	assign n_dec  = (vec_last && dok) ? 4'(dims12 - p12) : per;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			comp_q <= comp_value;
			code_q <= code_in;
			last_q <= vec_last;
		end
	end

	assign slot      = (cmd_q == OP_DEC) ? k_q : (pos_q[2:0] & 3'(per - 4'd1));
	assign used_bits = 8'(bits) * (8'(slot) + 8'd1);
	assign sh        = 3'(8'd8 - used_bits);
	assign ecode     = (code_q >> sh) & mask;
	assign placed    = (fcode_q & mask) << sh;
	assign acc_new   = acc_q | placed;
	assign emit_enc  = ({1'b0, slot} == per - 4'd1) || last_q;
	assign elem_last = ({1'b0, k_q} == cnt_q - 4'd1);
	assign fin_dec   = last_q && elem_last;

	assign r_mn   = oor_s1 ? 32'sd0 : rd_s1.mn;
	assign r_mx   = oor_s1 ? 32'sd0 : rd_s1.mx;
	assign r_mean = oor_s1 ? 32'sd0 : rd_s1.mean;
	assign r_sd   = oor_s1 ? 31'd0 : rd_s1.sd;
	assign half   = {2'b00, r_sd} + {1'b0, r_sd, 1'b0};
	assign mean36 = 36'(r_mean);
	assign half36 = signed'(36'(half));

	always_ff @(posedge clk) begin
		if (ctl.rng) begin
			lo_s2  <= qmode_q ? sat32(mean36 - half36) : r_mn;
			hi_s2  <= qmode_q ? sat32(mean36 + half36) : r_mx;
			std_s2 <= r_sd;
			thp_s2 <= 54'(thr_q) * 54'(r_sd);
		end
	end

	assign val55 = 55'(comp_q);
	assign t55   = signed'(55'(thp_s2 >> FRAC_BITS));

	always_ff @(posedge clk) begin
		if (ctl.p1) begin
			n_s3    <= 33'(comp_q) - 33'(lo_s2);
			d_s3    <= 33'(hi_s2) - 33'(lo_s2);
			le_s3   <= hi_s2 <= lo_s2;
			npos_s3 <= comp_q > lo_s2;
			nlt_s3  <= (33'(comp_q) - 33'(lo_s2)) < (33'(hi_s2) - 33'(lo_s2));
			gt_s3   <= val55 > t55;
			lt_s3   <= val55 < -t55;
		end
	end

	assign mul_a = (cmd_q == OP_DEC) ? d_s3 : n_s3;
	assign mul_b = signed'({1'b0, (cmd_q == OP_DEC) ? ecode : lm1});
	assign prod  = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (ctl.p2) begin
			prod_s4 <= prod;
		end
	end

	assign p2x    = {prod_s4, 1'b0};
	assign a_dec  = p2x + signed'(43'(lm1));
	assign an_dec = signed'(43'(lm1)) - 43'sd1 - p2x;

	always_ff @(posedge clk) begin
		if (ctl.p3) begin
			if (cmd_q == OP_DEC) begin
				neg_s5 <= a_dec < 0;
				num_s5 <= (a_dec < 0) ? NUM_W'(an_dec) : NUM_W'(a_dec);
				den_s5 <= DEN_W'({lm1, 1'b0});
			end else begin
				neg_s5 <= 1'b0;
				num_s5 <= NUM_W'(p2x + 43'(d_s3));
				den_s5 <= DEN_W'({d_s3, 1'b0});
			end
		end
	end

	sqc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.num    (num_s5),
		.den    (den_s5),
		.busy   (div_busy),
		.quo    (quo)
	);

	assign one_fx = 32'sd1 <<< FRAC_BITS;
	assign std_fx = signed'({1'b0, std_s2});
	assign sq     = neg_s5 ? -signed'(36'(quo)) : signed'(36'(quo));
	assign vsum   = 36'(lo_s2) + sq;

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			if (qtype_q == QT_BIN) begin
				fcode_q <= {7'd0, !comp_q[31]};
			end else if (qtype_q == QT_TER) begin
				fcode_q <= gt_s3 ? 8'd2 : (lt_s3 ? 8'd0 : 8'd1);
			end else if (le_s3 || !npos_s3) begin
				fcode_q <= 8'd0;
			end else if (!nlt_s3) begin
				fcode_q <= lm1;
			end else begin
				fcode_q <= quo[7:0];
			end
			if (qtype_q == QT_BIN) begin
				fval_q <= (ecode != 8'd0) ? one_fx : -one_fx;
			end else if (qtype_q == QT_TER) begin
				fval_q <= (ecode == 8'd2) ? std_fx : ((ecode == 8'd0) ? -std_fx : 32'sd0);
			end else begin
				fval_q <= sat32(vsum);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			acc_q <= '0;
			k_q   <= '0;
			cnt_q <= '0;
			ok_q  <= 1'b0;
		end else if (ctl.load) begin
			k_q   <= '0;
			cnt_q <= (cmd == OP_DEC) ? n_dec : 4'd1;
			ok_q  <= dok;
		end else if (ctl.step) begin
			if (cmd_q == OP_DEC) begin
				if (!elem_last) begin
					k_q <= k_q + 3'd1;
				end else if (last_q) begin
					pos_q <= '0;
					acc_q <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(cnt_q);
				end
			end else if (emit_enc) begin
				acc_q <= '0;
				pos_q <= last_q ? '0 : count[POS_W-1:0];
			end else begin
				acc_q <= acc_new;
				pos_q <= count[POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.step && sts.need_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && sts.need_out) begin
			if (cmd_q == OP_DEC) begin
				kind_q     <= 1'b1;
				packed_q   <= 8'd0;
				recon_q    <= fval_q;
				run_last_q <= fin_dec;
				lerr_q     <= fin_dec && !ok_q;
			end else begin
				kind_q     <= 1'b0;
				packed_q   <= acc_new;
				recon_q    <= 32'sd0;
				run_last_q <= last_q;
				lerr_q     <= last_q && (count != dims12);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign packed_code  = packed_q;
	assign recon_value  = recon_q;
	assign run_last     = run_last_q;
	assign length_error = lerr_q;

	always_comb begin
		sts           = '0;
		sts.in_elem   = (cmd == OP_ENC) || (cmd == OP_DEC);
		sts.div_need  = (qtype_q != QT_BIN) && (qtype_q != QT_TER)
			&& ((cmd_q == OP_DEC) || (!le_s3 && npos_s3 && nlt_s3));
		sts.div_busy  = div_busy;
		sts.need_out  = (cmd_q == OP_DEC) || emit_enc;
		sts.out_free  = !out_valid_q || out_ready;
		sts.elem_last = elem_last;
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step && sts.need_out) |-> sts.out_free)
		else $error("result beat overwritten before taken");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_enc_last_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step && cmd_q == OP_ENC && last_q) |=> (pos_q == '0 && acc_q == '0))
		else $error("position or packing byte not cleared after last component");

endmodule

>>> rtl/sqc_ctrl.sv
// ----------------------------------------------------------------------------
// sqc_ctrl
// Sequencer: accepts an item; for encode or decode it walks each code of it
// through read, range, multiply, divide when needed, finish and emit steps.
// ----------------------------------------------------------------------------
module sqc_ctrl import sqc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  sqc_sts_t sts,
	output sqc_cmd_t ctl
);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_RNG, S_P1, S_P2, S_P3, S_DIVGO, S_DIVWAIT, S_FIN, S_EMIT
	} state_t;

	state_t state_q;
	logic   step;

	assign in_ready = state_q == S_IDLE;
	assign step     = (state_q == S_EMIT) && (!sts.need_out || sts.out_free);

	always_comb begin
		ctl           = '0;
		ctl.load      = in_ready && in_valid;
		ctl.rd        = state_q == S_RD;
		ctl.rng       = state_q == S_RNG;
		ctl.p1        = state_q == S_P1;
		ctl.p2        = state_q == S_P2;
		ctl.p3        = state_q == S_P3;
		ctl.div_start = state_q == S_DIVGO;
		ctl.fin       = state_q == S_FIN;
		ctl.step      = step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:    if (in_valid && sts.in_elem) state_q <= S_RD;
				S_RD:      state_q <= S_RNG;
				S_RNG:     state_q <= S_P1;
				S_P1:      state_q <= S_P2;
				S_P2:      state_q <= S_P3;
				S_P3:      state_q <= sts.div_need ? S_DIVGO : S_FIN;
				S_DIVGO:   state_q <= S_DIVWAIT;
				S_DIVWAIT: if (!sts.div_busy) state_q <= S_FIN;
				S_FIN:     state_q <= S_EMIT;
				S_EMIT:    if (step) state_q <= sts.elem_last ? S_IDLE : S_RD;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/scalar_quantizer_codec.sv
// ----------------------------------------------------------------------------
// scalar_quantizer_codec
// Per-dimension scalar quantizer codec in signed fixed point: loads
// statistics, encodes components into packed code bytes, decodes bytes.
//
// Channel   Direction  Handshake             Beat
// in        in         in_valid/in_ready     one command with its fields
// out       out        out_valid/out_ready   one packed byte or one value
// config    in         wr_en                 one register write
//
// A load or unused command is taken and done in the idle state. Each code
// of an encode or decode passes the read, range, P1, P2, P3, finish and
// emit states, with divider start and wait states when it goes through the
// shared radix-2 divider. A decode byte handles its 1 to 8 codes one after
// the other. No clearing pass after reset. Items are taken only while the
// sequencer is idle; a held result stalls the next emit step only.
// ----------------------------------------------------------------------------
module scalar_quantizer_codec import sqc_pkg::*; #(
	parameter int DIM_MAX   = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [9:0]         dim_index,
	input  logic signed [31:0] comp_value,
	input  logic [7:0]         code_in,
	input  logic signed [31:0] stat_min,
	input  logic signed [31:0] stat_max,
	input  logic signed [31:0] stat_mean,
	input  logic [30:0]        stat_std,
	input  logic               vec_last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic [7:0]         packed_code,
	output logic signed [31:0] recon_value,
	output logic               run_last,
	output logic               length_error,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [CFG_W-1:0]   wr_data
);

	sqc_cmd_t ctl;
	sqc_sts_t sts;

	sqc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	sqc_dp #(
		.DIM_MAX   (DIM_MAX),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.dim_index    (dim_index),
		.comp_value   (comp_value),
		.code_in      (code_in),
		.stat_min     (stat_min),
		.stat_max     (stat_max),
		.stat_mean    (stat_mean),
		.stat_std     (stat_std),
		.vec_last     (vec_last),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.packed_code  (packed_code),
		.recon_value  (recon_value),
		.run_last     (run_last),
		.length_error (length_error),
		.ctl          (ctl),
		.sts          (sts)
	);

endmodule

>>> dv/tb_scalar_quantizer_codec.sv
// ----------------------------------------------------------------------------
// tb_scalar_quantizer_codec
// Self-checking bench for the scalar quantizer codec. The statistics of the
// low dimensions are loaded first, then a directed table and random
// encode/decode vectors run under several register settings. Every beat is
// compared with a typed row's own beat or the cycle-free model in this bench.
// ----------------------------------------------------------------------------
module tb_scalar_quantizer_codec;
	import sqc_pkg::*;

	localparam int NDIM = 1024;
	localparam int NLOAD = 32;
	localparam int WDOG_LIMIT = 20000;

	typedef struct {
		logic              kind;
		logic [7:0]        code;
		logic signed [31:0] value;
		logic              last;
		logic              lerr;
	} beat_t;

	typedef struct {
		bit         is_cfg;
		logic [1:0] op;
		logic [9:0] dim;
		logic [31:0] comp;
		logic [7:0] code;
		logic       last;
		bit         typed;
		beat_t      want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = OP_LOAD;
	logic [9:0] dim_index = '0;
	logic signed [31:0] comp_value = '0;
	logic [7:0] code_in = '0;
	logic signed [31:0] stat_min = '0, stat_max = '0, stat_mean = '0;
	logic [30:0] stat_std = '0;
	logic vec_last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic result_kind;
	logic [7:0] packed_code;
	logic signed [31:0] recon_value;
	logic run_last, length_error;
	logic wr_en = 1'b0;
	logic [1:0] wr_index = '0;
	logic [CFG_W-1:0] wr_data = '0;

	longint min_t[NDIM], max_t[NDIM], mean_t[NDIM], std_t[NDIM];
	int unsigned pos_m, accum_m;
	logic [2:0] qt_m;
	logic qm_m;
	int unsigned dims_m, thr_m;

	beat_t pending_q[$];
	int mismatches = 0;
	int tx_idle = 0, rx_idle = 0;
	int quiet = 0;

	always #4 clk = ~clk;

	scalar_quantizer_codec u_top (.*);

	function automatic int unsigned code_width(logic [2:0] t);
		case (t)
			QT_BIN: return 1;
			QT_TER, QT_TWO: return 2;
			QT_FOUR: return 4;
			default: return 8;
		endcase
	endfunction

	function automatic longint level_top(logic [2:0] t);
		case (t)
			QT_BIN: return 1;
			QT_TER: return 2;
			QT_TWO: return 3;
			QT_FOUR: return 15;
			default: return 255;
		endcase
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint std_at(int unsigned d);
		return d < NDIM ? std_t[d] : 0;
	endfunction

	function automatic void span_of(int unsigned d, output longint lo, output longint hi);
		longint half, m;
		if (d >= NDIM) begin
			lo = 0;
			hi = 0;
		end else if (qm_m == 1'b0) begin
			lo = min_t[d];
			hi = max_t[d];
		end else begin
			half = 3 * std_t[d];
			m = mean_t[d];
			lo = clip32(m - half);
			hi = clip32(m + half);
		end
	endfunction

	function automatic int unsigned quantize(longint v, int unsigned d);
		longint lo, hi, n, s, t, lm;
		if (qt_m == QT_BIN) return v >= 0 ? 1 : 0;
		if (qt_m == QT_TER) begin
			t = (longint'(thr_m) * std_at(d)) >>> 16;
			if (v > t) return 2;
			if (v < -t) return 0;
			return 1;
		end
		span_of(d, lo, hi);
		lm = level_top(qt_m);
		if (hi <= lo) return 0;
		n = v - lo;
		s = hi - lo;
		if (n <= 0) return 0;
		if (n >= s) return int'(lm);
		return int'((n * lm * 2 + s) / (2 * s));
	endfunction

	function automatic longint reconstruct(int unsigned c, int unsigned d);
		longint lo, hi, num, den, q;
		if (qt_m == QT_BIN) return c != 0 ? 65536 : -65536;
		if (qt_m == QT_TER) begin
			if (c == 2) return std_at(d);
			if (c == 0) return -std_at(d);
			return 0;
		end
		span_of(d, lo, hi);
		num = 2 * longint'(c) * (hi - lo) + level_top(qt_m);
		den = 2 * level_top(qt_m);
		q = num / den;
		if ((num % den) != 0 && num < 0) q--;
		return clip32(lo + q);
	endfunction

	// model one accepted input beat; returns expected beats
	function automatic void codec_step(logic [1:0] op, logic [9:0] d, logic [31:0] comp,
			logic [7:0] cin, logic last, ref beat_t outs[$]);
		int unsigned w, per, mask, slot, c, cnt, p, n, k;
		bit ok;
		beat_t b;
		w = code_width(qt_m);
		per = 8 / w;
		mask = (1 << w) - 1;
		outs = {};
		if (op == OP_ENC) begin
			slot = pos_m % per;
			c = quantize(longint'($signed(comp)), pos_m) & mask;
			cnt = pos_m + 1;
			accum_m = (accum_m | (c << (8 - w * (slot + 1)))) & 8'hFF;
			if (slot != per - 1 && !last) begin
				pos_m = cnt & 11'h7FF;
				return;
			end
			b.kind = 1'b0;
			b.code = accum_m[7:0];
			b.value = '0;
			b.last = last;
			b.lerr = last && cnt != dims_m;
			outs.push_back(b);
			accum_m = 0;
			pos_m = last ? 0 : (cnt & 11'h7FF);
		end else if (op == OP_DEC) begin
			p = pos_m;
			n = per;
			ok = 1;
			if (last) begin
				ok = dims_m >= 1 && p <= dims_m - 1 && dims_m - 1 < p + per;
				if (ok) n = dims_m - p;
			end
			for (k = 0; k < n; k++) begin
				c = (cin >> (8 - w * (k + 1))) & mask;
				b.kind = 1'b1;
				b.code = '0;
				b.value = 32'(reconstruct(c, (p + k) & 11'h7FF));
				b.last = last && k == n - 1;
				b.lerr = b.last && !ok;
				outs.push_back(b);
			end
			if (last) begin
				pos_m = 0;
				accum_m = 0;
			end else begin
				pos_m = (p + n) & 11'h7FF;
			end
		end
	endfunction

	always @(posedge clk) begin
		beat_t e;
		if (arst_n) out_ready <= ($urandom_range(99) >= rx_idle);
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > WDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
		if (out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat code=%h value=%h",
					packed_code, recon_value);
			end else begin
				e = pending_q.pop_front();
				if (e.kind !== result_kind || e.code !== packed_code ||
						e.value !== recon_value || e.last !== run_last ||
						e.lerr !== length_error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp k%0d %h %h l%0d e%0d got k%0d %h %h l%0d e%0d",
							e.kind, e.code, e.value, e.last, e.lerr, result_kind,
							packed_code, recon_value, run_last, length_error);
				end
			end
		end
	end

	task automatic drain(int extra);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_q.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned val);
		drain(100);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val[CFG_W-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_QTYPE: qt_m = val[2:0];
			REG_QMODE: qm_m = val[0];
			REG_DIMS: dims_m = val & 32'h7FF;
			default: thr_m = val & 32'h7FFFFF;
		endcase
	endtask

	task automatic send_beat(logic [1:0] op, logic [9:0] d, logic [31:0] comp, logic [7:0] cin,
			logic [31:0] smin, logic [31:0] smax, logic [31:0] smean, logic [30:0] sstd,
			logic last, bit typed, beat_t want);
		beat_t outs[$];
		if ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		dim_index <= d;
		comp_value <= comp;
		code_in <= cin;
		stat_min <= smin;
		stat_max <= smax;
		stat_mean <= smean;
		stat_std <= sstd;
		vec_last <= last;
		do @(posedge clk); while (!in_ready);
		if (op == OP_LOAD) begin
			min_t[d] = longint'($signed(smin));
			max_t[d] = longint'($signed(smax));
			mean_t[d] = longint'($signed(smean));
			std_t[d] = longint'(sstd);
		end
		codec_step(op, d, comp, cin, last, outs);
		if (typed) pending_q.push_back(want);
		else foreach (outs[i]) pending_q.push_back(outs[i]);
	endtask

	task automatic load_dim(logic [9:0] d);
		logic [31:0] lo, span;
		beat_t none;
		lo = $urandom;
		span = $urandom_range(3) == 0 ? $urandom : ($urandom >> $urandom_range(24, 4));
		send_beat(OP_LOAD, d, $urandom, 8'($urandom), lo, lo + span, $urandom,
			31'($urandom_range(1) ? $urandom : ($urandom >> $urandom_range(28, 8))),
			1'b0, 0, none);
	endtask

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom >> $urandom_range(30, 12);
			2: return -($urandom >> $urandom_range(30, 12));
			default: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
		endcase
	endfunction

	task automatic run_vector(bit decode);
		int unsigned len, per, nb;
		beat_t none;
		per = 8 / code_width(qt_m);
		len = $urandom_range(99) < 80 ? dims_m : $urandom_range(dims_m + 3, 1);
		nb = decode ? (len + per - 1) / per : len;
		for (int i = 0; i < nb; i++) begin
			if ($urandom_range(19) == 0)
				send_beat(2'd3, 10'($urandom), $urandom, 8'($urandom), $urandom, $urandom,
					$urandom, 31'($urandom), 1'($urandom), 0, none);
			send_beat(decode ? OP_DEC : OP_ENC, 10'($urandom), rand_comp(), 8'($urandom),
				$urandom, $urandom, $urandom, 31'($urandom), i == nb - 1, 0, none);
		end
	endtask

	row_t dir_rows[$];

	function automatic row_t mk(bit c, logic [1:0] op, logic [31:0] comp, logic [7:0] cin,
			logic last, bit typed = 0, logic k = 0, logic [7:0] pc = 0,
			logic [31:0] rv = 0, logic le = 0);
		row_t r;
		r.is_cfg = c;
		r.op = op;
		r.dim = '0;
		r.comp = comp;
		r.code = cin;
		r.last = last;
		r.typed = typed;
		r.want.kind = k;
		r.want.code = pc;
		r.want.value = rv;
		r.want.last = last;
		r.want.lerr = le;
		return r;
	endfunction

	initial begin
		beat_t none;
		int items;
		qt_m = QTYPE_RST;
		qm_m = QMODE_RST;
		dims_m = DIMS_RST;
		thr_m = THRESH_RST;
		pos_m = 0;
		accum_m = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int d = 0; d < NLOAD; d++) load_dim(d);

		// write index in op field, value in comp field for config rows
		dir_rows = '{
			mk(0, OP_ENC, 32'h7FFFFFFF, 0, 0), mk(0, OP_ENC, 32'h80000000, 0, 0),
			mk(0, OP_DEC, 0, 8'hFF, 0), mk(0, OP_DEC, 0, 8'h00, 1),
			mk(1, REG_QTYPE, QT_BIN, 0, 0), mk(1, REG_DIMS, 1, 0, 0),
			mk(0, OP_ENC, 0, 0, 1, 1, 0, 8'h80, 0, 0),
			mk(0, OP_ENC, 32'hFFFFFFFF, 0, 1, 1, 0, 8'h00, 0, 0),
			mk(0, OP_DEC, 0, 8'hFF, 1, 1, 1, 0, 32'h00010000, 0),
			mk(0, OP_DEC, 0, 8'h00, 1, 1, 1, 0, 32'hFFFF0000, 0),
			mk(0, OP_ENC, 5, 0, 0), mk(0, OP_ENC, 7, 0, 1, 1, 0, 8'hC0, 0, 1),
			mk(0, 2'd3, 0, 0, 1),
			mk(1, REG_QTYPE, QT_TER, 0, 0), mk(1, REG_THRESH, 23'h7FFFFF, 0, 0),
			mk(1, REG_DIMS, 4, 0, 0), mk(0, OP_ENC, 32'h7FFFFFFF, 0, 0),
			mk(0, OP_ENC, 0, 0, 0), mk(0, OP_ENC, 32'h80000000, 0, 1),
			mk(0, OP_DEC, 0, 8'h9C, 1), mk(1, REG_QMODE, 0, 0, 0),
			mk(1, REG_QTYPE, QT_FOUR, 0, 0), mk(0, OP_ENC, 32'h80000000, 0, 0),
			mk(0, OP_ENC, 32'h7FFFFFFF, 0, 0), mk(0, OP_DEC, 0, 8'hF0, 1)
		};
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) write_reg(dir_rows[i].op, dir_rows[i].comp);
			else begin
				if (dir_rows[i].typed) drain(0);
				send_beat(dir_rows[i].op, dir_rows[i].dim, dir_rows[i].comp, dir_rows[i].code,
					0, 0, 0, 0, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		items = 0;
		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = ph == 0 ? 13 : (ph == 1 ? 50 : 0);
			rx_idle = ph == 0 ? 50 : (ph == 1 ? 13 : 0);
			for (int s = 0; s < 5; s++) begin
				write_reg(REG_QTYPE, $urandom_range(7));
				write_reg(REG_QMODE, $urandom_range(1));
				write_reg(REG_THRESH, s == 0 ? 0 : (s == 1 ? 23'h400000 : $urandom_range(23'h7FFFFF)));
				write_reg(REG_DIMS, (ph == 2 && s == 4) ? 1024 : (s == 3 ? 1 : $urandom_range(16, 1)));
				for (int v = 0; v < 6 && items < 480; v++) begin
					if (dims_m == 1024) begin
						for (int i = 0; i < 5; i++)
							send_beat(OP_ENC, 0, rand_comp(), 0, 0, 0, 0, 0, i == 4, 0, none);
						items += 5;
					end else begin
						if ($urandom_range(3) == 0) load_dim(10'($urandom_range(NLOAD - 1)));
						run_vector($urandom_range(1));
						items += dims_m;
					end
					if (v == 2) drain(0);
				end
			end
		end

		drain(200);
		if (mismatches == 0 && pending_q.size() == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
rtl/sqc_pkg.sv
rtl/sqc_div.sv
rtl/sqc_dp.sv
rtl/sqc_ctrl.sv
rtl/scalar_quantizer_codec.sv
dv/tb_scalar_quantizer_codec.sv
